>>> rtl/diq_pkg.sv
// diq_pkg: shared types, codes and sizes of the io delay injection queue
// used by every module under rtl; depends on nothing
package diq_pkg;

    localparam int TAG_W        = 16;
    localparam int ADDR_W       = 63;
    localparam int OFF_W        = 40;
    localparam int DLY_W        = 20;
    localparam int TICK_W       = 32;
    localparam int PEND_W       = 5;
    localparam int CFG_W        = 40;
    localparam int CFG_IDX_W    = 2;

    localparam int QUEUE_DEPTH  = 16;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // sector size must be a power of two
    localparam int SECTOR_BYTES = 512;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

    localparam int OPQ_DEPTH    = 2;
    localparam int OPQ_PTR_W    = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W    = $clog2(OPQ_DEPTH + 1);

    // function codes of an input beat
    localparam logic [1:0] FN_REQUEST = 2'd0;
    localparam logic [1:0] FN_TICK    = 2'd1;
    localparam logic [1:0] FN_DRAIN   = 2'd2;

    // request kinds
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;
    localparam logic [1:0] CMD_OTHER  = 2'd3;

    // result status
    localparam logic [1:0] ST_RELEASED = 2'd0;
    localparam logic [1:0] ST_PASSED   = 2'd1;
    localparam logic [1:0] ST_REFUSED  = 2'd2;

    // device select
    localparam logic DEV_READ  = 1'b0;
    localparam logic DEV_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READ_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_DELAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_OFFSET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_DELAY  = 2'd3;

    typedef enum logic [2:0] {
        OP_BYPASS = 3'd0,
        OP_REMAP  = 3'd1,
        OP_ENQ    = 3'd2,
        OP_TICK   = 3'd3,
        OP_DRAIN  = 3'd4
    } op_kind_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [1:0]        command;
        logic [TAG_W-1:0]  request_tag;
        logic [ADDR_W-1:0] request_byte_offset;
    } in_item_t;

    typedef struct packed {
        logic [TAG_W-1:0]  out_tag;
        logic [ADDR_W-1:0] out_byte_offset;
        logic              out_device;
        logic [1:0]        out_status;
        logic              out_last;
        logic [PEND_W-1:0] read_pending;
        logic [PEND_W-1:0] write_pending;
    } out_item_t;

    typedef struct packed {
        logic [OFF_W-1:0] read_offset_sectors;
        logic [DLY_W-1:0] read_delay_ticks;
        logic [OFF_W-1:0] write_offset_sectors;
        logic [DLY_W-1:0] write_delay_ticks;
    } cfg_t;

    typedef struct packed {
        op_kind_t          kind;
        logic              dev;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] addr;
    } op_t;

endpackage

>>> rtl/diq_front.sv
// diq_front: accepts input beats and turns them into back-end operations
// depends on diq_pkg
module diq_front (
    input  diq_pkg::in_item_t req,
    input  logic              req_valid,
    output logic              req_ready,
    input  diq_pkg::cfg_t     cfg,
    input  logic              q_full,
    output logic              push,
    output diq_pkg::op_t      push_op
);
    import diq_pkg::*;

    logic known;

    assign req_ready = !q_full;

    always_comb
    begin
        known         = 1'b1;
        push_op.tag   = req.request_tag;
        push_op.addr  = req.request_byte_offset;
        push_op.dev   = DEV_WRITE;
        push_op.kind  = OP_BYPASS;
        unique case (req.func)
            FN_REQUEST:
            begin
                unique case (req.command) inside
                    CMD_READ:
                    begin
                        push_op.dev  = DEV_READ;
                        push_op.kind = (cfg.read_delay_ticks == '0) ? OP_REMAP : OP_ENQ;
                    end
                    CMD_WRITE, CMD_FLUSH:
                    begin
                        push_op.dev  = DEV_WRITE;
                        push_op.kind = (cfg.write_delay_ticks == '0) ? OP_REMAP : OP_ENQ;
                    end
                    default:
                    begin
                        // other commands skip the queues and the remap
                        push_op.dev  = DEV_WRITE;
                        push_op.kind = OP_BYPASS;
                    end
                endcase
            end
            FN_TICK:  push_op.kind = OP_TICK;
            FN_DRAIN: push_op.kind = OP_DRAIN;
            default:  known = 1'b0;
        endcase
    end

    // unused function codes are taken and dropped
    assign push = req_valid && req_ready && known;

endmodule

>>> rtl/diq_op_queue.sv
// diq_op_queue: short queue of operations between front and back
// depends on diq_pkg
module diq_op_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  diq_pkg::op_t push_op,
    output logic         full,
    input  logic         pop,
    output logic         pop_valid,
    output diq_pkg::op_t pop_op
);
    import diq_pkg::*;

    op_t                  op_reg [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OPQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OPQ_CNT_W-1:0] count_reg, count_next;

    function automatic logic [OPQ_PTR_W-1:0] ptr_inc(input logic [OPQ_PTR_W-1:0] p);
        return (p == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == OPQ_CNT_W'(OPQ_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_op    = op_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            op_reg[wr_ptr_reg] <= push_op;
    end

endmodule

>>> rtl/diq_back.sv
// diq_back: delay queues, tick counter, release sequencer and output register
// depends on diq_pkg
module diq_back (
    input  logic               clk,
    input  logic               rst_n,
    input  diq_pkg::cfg_t      cfg,
    input  logic               op_valid,
    input  diq_pkg::op_t       op,
    output logic               op_pop,
    output diq_pkg::out_item_t rsp,
    output logic               rsp_valid,
    input  logic               rsp_ready
);
    import diq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REL_RD = 4'b0010,
        S_REL_WR = 4'b0100,
        S_FLUSH  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [TAG_W-1:0]  rd_tag_reg  [QUEUE_DEPTH];
    logic [ADDR_W-1:0] rd_addr_reg [QUEUE_DEPTH];
    logic [TICK_W-1:0] rd_exp_reg  [QUEUE_DEPTH];
    logic [TAG_W-1:0]  wr_tag_reg  [QUEUE_DEPTH];
    logic [ADDR_W-1:0] wr_addr_reg [QUEUE_DEPTH];
    logic [TICK_W-1:0] wr_exp_reg  [QUEUE_DEPTH];

    logic [QPTR_W-1:0] rd_head_reg, rd_head_next;
    logic [QPTR_W-1:0] wr_head_reg, wr_head_next;
    logic [QCNT_W-1:0] rd_fill_reg, rd_fill_next;
    logic [QCNT_W-1:0] wr_fill_reg, wr_fill_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic              drain_reg, drain_next;

    logic      hold_valid_reg, hold_valid_next;
    out_item_t hold_reg, hold_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic              out_free;
    logic              rd_hit, wr_hit;
    logic              rd_full, wr_full;
    out_item_t         rd_item, wr_item;
    logic              enq_we;
    logic [QPTR_W-1:0] enq_slot;
    logic [TICK_W-1:0] enq_exp;
    logic [DLY_W-1:0]  op_delay;
    logic [QCNT_W-1:0] op_fill;
    logic [QPTR_W-1:0] op_head;

    function automatic logic [QPTR_W-1:0] wrap_add(input logic [QPTR_W-1:0] h,
                                                   input logic [QCNT_W-1:0] n);
        logic [QCNT_W:0] s;
        s = (QCNT_W+1)'(h) + (QCNT_W+1)'(n);
        if (s >= (QCNT_W+1)'(QUEUE_DEPTH))
            s = s - (QCNT_W+1)'(QUEUE_DEPTH);
        return s[QPTR_W-1:0];
    endfunction

    // expired when now is strictly after the stamp, modulo wrap
    function automatic logic expired(input logic [TICK_W-1:0] now,
                                     input logic [TICK_W-1:0] stamp);
        logic [TICK_W-1:0] d;
        d = now - stamp;
        return (d != '0) && !d[TICK_W-1];
    endfunction

    function automatic logic [ADDR_W-1:0] remap(input logic [ADDR_W-1:0] a,
                                                input logic [OFF_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = (ADDR_W+1)'(a) + ((ADDR_W+1)'(off) << SECTOR_SHIFT);
        return sum[ADDR_W] ? '1 : sum[ADDR_W-1:0];
    endfunction

    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

    assign rd_full = (rd_fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign wr_full = (wr_fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_hit  = (rd_fill_reg != '0) && (drain_reg || expired(tick_reg, rd_exp_reg[rd_head_reg]));
    assign wr_hit  = (wr_fill_reg != '0) && (drain_reg || expired(tick_reg, wr_exp_reg[wr_head_reg]));

    assign op_delay = (op.dev == DEV_WRITE) ? cfg.write_delay_ticks : cfg.read_delay_ticks;
    assign op_fill  = (op.dev == DEV_WRITE) ? wr_fill_reg : rd_fill_reg;
    assign op_head  = (op.dev == DEV_WRITE) ? wr_head_reg : rd_head_reg;
    assign enq_slot = wrap_add(op_head, op_fill);
    assign enq_exp  = tick_reg + TICK_W'(op_delay);

    always_comb
    begin
        rd_item.out_tag         = rd_tag_reg[rd_head_reg];
        rd_item.out_byte_offset = remap(rd_addr_reg[rd_head_reg], cfg.read_offset_sectors);
        rd_item.out_device      = DEV_READ;
        rd_item.out_status      = ST_RELEASED;
        rd_item.out_last        = 1'b0;
        rd_item.read_pending    = PEND_W'(rd_fill_reg - 1'b1);
        rd_item.write_pending   = PEND_W'(wr_fill_reg);

        wr_item.out_tag         = wr_tag_reg[wr_head_reg];
        wr_item.out_byte_offset = remap(wr_addr_reg[wr_head_reg], cfg.write_offset_sectors);
        wr_item.out_device      = DEV_WRITE;
        wr_item.out_status      = ST_RELEASED;
        wr_item.out_last        = 1'b0;
        wr_item.read_pending    = PEND_W'(rd_fill_reg);
        wr_item.write_pending   = PEND_W'(wr_fill_reg - 1'b1);
    end

    always_comb
    begin
        state_next      = state_reg;
        rd_head_next    = rd_head_reg;
        wr_head_next    = wr_head_reg;
        rd_fill_next    = rd_fill_reg;
        wr_fill_next    = wr_fill_reg;
        tick_next       = tick_reg;
        drain_next      = drain_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_next        = out_reg;
        op_pop          = 1'b0;
        enq_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid && out_free)
                begin
                    op_pop                   = 1'b1;
                    // single-result beats go straight to the output register
                    out_next.out_tag         = op.tag;
                    out_next.out_byte_offset = op.addr;
                    out_next.out_device      = op.dev;
                    out_next.out_status      = ST_PASSED;
                    out_next.out_last        = 1'b1;
                    out_next.read_pending    = PEND_W'(rd_fill_reg);
                    out_next.write_pending   = PEND_W'(wr_fill_reg);
                    unique case (op.kind)
                        OP_BYPASS:
                            out_valid_next = 1'b1;
                        OP_REMAP:
                        begin
                            out_valid_next = 1'b1;
                            out_next.out_byte_offset = remap(op.addr,
                                (op.dev == DEV_WRITE) ? cfg.write_offset_sectors
                                                      : cfg.read_offset_sectors);
                        end
                        OP_ENQ:
                        begin
                            if ((op.dev == DEV_WRITE) ? wr_full : rd_full)
                            begin
                                out_valid_next      = 1'b1;
                                out_next.out_status = ST_REFUSED;
                            end
                            else
                            begin
                                enq_we = 1'b1;
                                if (op.dev == DEV_WRITE)
                                    wr_fill_next = wr_fill_reg + 1'b1;
                                else
                                    rd_fill_next = rd_fill_reg + 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            tick_next  = tick_reg + 1'b1;
                            drain_next = 1'b0;
                            state_next = S_REL_RD;
                        end
                        OP_DRAIN:
                        begin
                            drain_next = 1'b1;
                            state_next = S_REL_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_REL_RD:
            begin
                if (!rd_hit)
                    state_next = S_REL_WR;
                else if (!hold_valid_reg || out_free)
                begin
                    // previous release is not the last one: send it on
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = hold_reg;
                    end
                    hold_valid_next = 1'b1;
                    hold_next       = rd_item;
                    rd_head_next    = wrap_add(rd_head_reg, QCNT_W'(1));
                    rd_fill_next    = rd_fill_reg - 1'b1;
                end
            end
            S_REL_WR:
            begin
                if (!wr_hit)
                    state_next = S_FLUSH;
                else if (!hold_valid_reg || out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = hold_reg;
                    end
                    hold_valid_next = 1'b1;
                    hold_next       = wr_item;
                    wr_head_next    = wrap_add(wr_head_reg, QCNT_W'(1));
                    wr_fill_next    = wr_fill_reg - 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (!hold_valid_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next          = hold_reg;
                    out_next.out_last = 1'b1;
                    hold_valid_next   = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_head_reg    <= '0;
            wr_head_reg    <= '0;
            rd_fill_reg    <= '0;
            wr_fill_reg    <= '0;
            tick_reg       <= '0;
            drain_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_head_reg    <= rd_head_next;
            wr_head_reg    <= wr_head_next;
            rd_fill_reg    <= rd_fill_next;
            wr_fill_reg    <= wr_fill_next;
            tick_reg       <= tick_next;
            drain_reg      <= drain_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (enq_we && op.dev == DEV_READ)
        begin
            rd_tag_reg[enq_slot]  <= op.tag;
            rd_addr_reg[enq_slot] <= op.addr;
            rd_exp_reg[enq_slot]  <= enq_exp;
        end
        if (enq_we && op.dev == DEV_WRITE)
        begin
            wr_tag_reg[enq_slot]  <= op.tag;
            wr_addr_reg[enq_slot] <= op.addr;
            wr_exp_reg[enq_slot]  <= enq_exp;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_fill_reg <= QCNT_W'(QUEUE_DEPTH)) && (wr_fill_reg <= QCNT_W'(QUEUE_DEPTH)))
        else $error("queue fill above depth");

    a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (state_reg != S_IDLE))
        else $error("held release left behind in idle");

    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(tick_reg))
        else $error("tick counter moved during a release run");

    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) && !hold_valid_reg |=> (state_reg == S_IDLE))
        else $error("flush with nothing held did not return to idle");

endmodule

>>> rtl/io_delay_injection_queue.sv
// io_delay_injection_queue: top level, configuration registers and wiring
// depends on diq_pkg, diq_front, diq_op_queue, diq_back
//
//  channel  signals                       dir  payload
//  req      req_valid / req_ready         in   diq_pkg::in_item_t
//  rsp      rsp_valid / rsp_ready         out  diq_pkg::out_item_t
//  cfg      cfg_we, cfg_index, cfg_data   in   40-bit register write
//
// pass-through results come out at one per cycle while rsp is ready, and
// up to two operations wait in the front queue; a tick or drain releases
// due read entries, then due write entries, then the last held one, one
// release per cycle while rsp is ready, through the head read of each delay queue
// reset clears queues, tick counter and configuration; no clearing pass
// a stalled rsp channel stalls the back end, the front keeps queuing beats until the front queue is full
module io_delay_injection_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  diq_pkg::in_item_t             req,
    input  logic                          req_valid,
    output logic                          req_ready,
    output diq_pkg::out_item_t            rsp,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic                          cfg_we,
    input  logic [diq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [diq_pkg::CFG_W-1:0]     cfg_data
);
    import diq_pkg::*;

    cfg_t cfg_reg;
    logic q_full;
    logic push;
    op_t  push_op;
    logic op_pop;
    logic op_valid;
    op_t  op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_READ_OFFSET:  cfg_reg.read_offset_sectors  <= OFF_W'(cfg_data);
                CFG_READ_DELAY:   cfg_reg.read_delay_ticks     <= DLY_W'(cfg_data);
                CFG_WRITE_OFFSET: cfg_reg.write_offset_sectors <= OFF_W'(cfg_data);
                CFG_WRITE_DELAY:  cfg_reg.write_delay_ticks    <= DLY_W'(cfg_data);
                default: ;
            endcase
        end
    end

    diq_front u_front (
        .req       (req),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .push      (push),
        .push_op   (push_op)
    );

    diq_op_queue u_op_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (q_full),
        .pop       (op_pop),
        .pop_valid (op_valid),
        .pop_op    (op)
    );

    diq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .op_valid  (op_valid),
        .op        (op),
        .op_pop    (op_pop),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

endmodule
